[hdl/tpia_pkg.sv]
// Shared types and constants of the two-pool id allocator.
// Request and status codes, default pool sizes and the field widths of the stream ports.
// No dependencies.
package tpia_pkg;

  localparam int DEF_PLAYER_IDS  = 1024;
  localparam int DEF_MONSTER_IDS = 1024;

  localparam int ID_OUT_W = 12;  // given_id and release_id width on the ports
  localparam int TDATA_W  = 16;  // one id padded to whole bytes

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_PLAYER  = 2'd0,
    KIND_MONSTER = 2'd1,
    KIND_SHARED  = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  // Where the id of a held result comes from.
  typedef enum logic [1:0] {
    SRC_REG     = 2'd0,
    SRC_PLAYER  = 2'd1,
    SRC_MONSTER = 2'd2
  } id_src_t;

endpackage

[hdl/two_pool_id_allocator_unit.sv]
// Two-pool id allocator: player and monster free lists in synchronous RAM plus bump counters.
// Depends on tpia_pkg for codes, widths and default pool sizes.
//
// Usage
//   Requests enter on the s_axis channel, one transaction per request. tuser carries the
//   request type (func) and the object class (kind); tdata carries the id being released.
//   Every request yields exactly one result transaction on m_axis: tdata holds the given or
//   echoed id, tuser the status (ok, pool exhausted, release rejected).
//   An allocate pops the oldest released id of its pool, else takes the pool's next never-used
//   id, else reports exhaustion with id 0. The shared class always gets PLAYER_IDS+MONSTER_IDS.
//   A release pushes the id onto the free list of the pool it falls in; releasing the shared
//   id is accepted and dropped; ids beyond it, or a full free list, are rejected.
// Pipeline and throughput
//   An accepted request passes the held result, which waits for the free-list RAM read
//   (registered read port), and then the output register on its way to m_axis. One request is
//   taken per cycle while the output side keeps up; the held result and the output register
//   form a two-deep buffer, so a stalled receiver stops s_axis_tready after two results.
// Reset
//   rst empties both free lists, restarts the bump counters at 0 and PLAYER_IDS and drops any
//   held result. RAM contents are not cleared: an entry is only read after it was written.
module two_pool_id_allocator_unit
  import tpia_pkg::*;
#(
  parameter int PLAYER_IDS  = DEF_PLAYER_IDS,
  parameter int MONSTER_IDS = DEF_MONSTER_IDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [11:0] release_id, [15:12] zero
  input  logic [2:0]         s_axis_tuser,   // [0] func, [2:1] kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [11:0] given_id, [15:12] zero
  output logic [1:0]         m_axis_tuser    // [1:0] status
);

  localparam int SHARED = PLAYER_IDS + MONSTER_IDS;
  localparam int IDW    = $clog2(SHARED + 1);                 // holds every id incl. shared
  localparam int CW     = (IDW > ID_OUT_W) ? IDW : ID_OUT_W;  // compare width for release ids
  localparam int PAW    = (PLAYER_IDS > 1) ? $clog2(PLAYER_IDS) : 1;
  localparam int MAW    = (MONSTER_IDS > 1) ? $clog2(MONSTER_IDS) : 1;
  localparam int PCW    = $clog2(PLAYER_IDS + 1);
  localparam int MCW    = $clog2(MONSTER_IDS + 1);

  // Free-list storage
  logic [IDW-1:0] p_mem [PLAYER_IDS];
  logic [IDW-1:0] m_mem [MONSTER_IDS];
  logic [IDW-1:0] p_rdata;
  logic [IDW-1:0] m_rdata;

  // Free-list control and bump counters
  logic [PAW-1:0] p_head, p_tail;
  logic [PCW-1:0] p_count;
  logic [MAW-1:0] m_head, m_tail;
  logic [MCW-1:0] m_count;
  logic [PCW-1:0] next_player;
  logic [IDW-1:0] next_monster;

  // Held result (waits here for the registered RAM read)
  logic           pend_valid;
  logic [IDW-1:0] pend_id;
  status_t        pend_status;
  id_src_t        pend_src;

  // Output register
  logic           out_valid;
  logic [IDW-1:0] out_id;
  status_t        out_status;

  // Request decode
  func_t          req_func;
  kind_t          req_kind;
  logic [CW-1:0]  req_rid;
  logic           acc, pend_adv;
  logic           p_pop, p_bump, p_push, m_pop, m_bump, m_push;
  logic [IDW-1:0] dec_id;
  status_t        dec_status;
  id_src_t        dec_src;
  logic [IDW-1:0] sel_id;

  assign req_func = func_t'(s_axis_tuser[0]);
  assign req_kind = kind_t'(s_axis_tuser[2:1]);
  assign req_rid  = CW'(s_axis_tdata[ID_OUT_W-1:0]);

  // The held result moves on whenever the output register is free or being emptied.
  assign pend_adv      = pend_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !pend_valid || pend_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    p_pop      = 1'b0;
    p_bump     = 1'b0;
    p_push     = 1'b0;
    m_pop      = 1'b0;
    m_bump     = 1'b0;
    m_push     = 1'b0;
    dec_id     = '0;
    dec_status = ST_OK;
    dec_src    = SRC_REG;
    if (req_func == FUNC_ALLOC) begin
      case (req_kind)
        KIND_PLAYER: begin
          if (p_count != '0) begin
            p_pop   = 1'b1;
            dec_src = SRC_PLAYER;
          end else if (next_player < PCW'(PLAYER_IDS)) begin
            p_bump = 1'b1;
            dec_id = IDW'(next_player);
          end else begin
            dec_status = ST_EXHAUSTED;
          end
        end
        KIND_MONSTER: begin
          if (m_count != '0) begin
            m_pop   = 1'b1;
            dec_src = SRC_MONSTER;
          end else if (next_monster < IDW'(SHARED)) begin
            m_bump = 1'b1;
            dec_id = next_monster;
          end else begin
            dec_status = ST_EXHAUSTED;
          end
        end
        KIND_SHARED: dec_id = IDW'(SHARED);
        default:     dec_status = ST_EXHAUSTED;
      endcase
    end else begin
      // Echo the released id; port bits beyond IDW are dropped by the cast to IDW here.
      dec_id = IDW'(req_rid);
      if (req_rid < CW'(PLAYER_IDS)) begin
        if (p_count == PCW'(PLAYER_IDS)) dec_status = ST_REJECTED;
        else                             p_push     = 1'b1;
      end else if (req_rid < CW'(SHARED)) begin
        if (m_count == MCW'(MONSTER_IDS)) dec_status = ST_REJECTED;
        else                              m_push     = 1'b1;
      end else if (req_rid != CW'(SHARED)) begin
        dec_status = ST_REJECTED;
      end
    end
  end

  // Free-list RAMs: one write or one read per cycle each; read data holds until the next pop.
  always_ff @(posedge clk) begin
    if (acc && p_push) p_mem[p_tail] <= IDW'(req_rid);
    if (acc && p_pop)  p_rdata <= p_mem[p_head];
  end

  always_ff @(posedge clk) begin
    if (acc && m_push) m_mem[m_tail] <= IDW'(req_rid);
    if (acc && m_pop)  m_rdata <= m_mem[m_head];
  end

  // Pointer, count and bump counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      p_head       <= '0;
      p_tail       <= '0;
      p_count      <= '0;
      m_head       <= '0;
      m_tail       <= '0;
      m_count      <= '0;
      next_player  <= '0;
      next_monster <= IDW'(PLAYER_IDS);
    end else if (acc) begin
      if (p_pop) begin
        p_head  <= (p_head == PAW'(PLAYER_IDS - 1)) ? '0 : p_head + 1'b1;
        p_count <= p_count - 1'b1;
      end
      if (p_push) begin
        p_tail  <= (p_tail == PAW'(PLAYER_IDS - 1)) ? '0 : p_tail + 1'b1;
        p_count <= p_count + 1'b1;
      end
      if (m_pop) begin
        m_head  <= (m_head == MAW'(MONSTER_IDS - 1)) ? '0 : m_head + 1'b1;
        m_count <= m_count - 1'b1;
      end
      if (m_push) begin
        m_tail  <= (m_tail == MAW'(MONSTER_IDS - 1)) ? '0 : m_tail + 1'b1;
        m_count <= m_count + 1'b1;
      end
      if (p_bump) next_player  <= next_player + 1'b1;
      if (m_bump) next_monster <= next_monster + 1'b1;
    end
  end

  // Hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (acc) begin
      pend_valid <= 1'b1;
    end else if (pend_adv) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_id     <= dec_id;
      pend_status <= dec_status;
      pend_src    <= dec_src;
    end
  end

  always_comb begin
    case (pend_src)
      SRC_PLAYER:  sel_id = p_rdata;
      SRC_MONSTER: sel_id = m_rdata;
      default:     sel_id = pend_id;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      out_id     <= sel_id;
      out_status <= pend_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'(ID_OUT_W'(out_id));
  assign m_axis_tuser  = out_status;

  // Checks
  a_p_count_range: assert property (@(posedge clk) disable iff (rst)
    p_count <= PCW'(PLAYER_IDS))
    else $error("player free list over capacity");

  a_m_count_range: assert property (@(posedge clk) disable iff (rst)
    m_count <= MCW'(MONSTER_IDS))
    else $error("monster free list over capacity");

  a_p_ptrs: assert property (@(posedge clk) disable iff (rst)
    (p_count == '0 || p_count == PCW'(PLAYER_IDS)) |-> (p_head == p_tail))
    else $error("player free list pointers out of step with count");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_adv) |=> pend_valid)
    else $error("held result dropped while output busy");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_EXHAUSTED) |-> (out_id == '0))
    else $error("exhaustion reported with nonzero id");

endmodule
